@@ design/led_matrix_draw_engine_assert.svh @@
// Assertion macros for the LED matrix draw engine.
// Each takes a label, clock, active-low reset, a trigger and a consequence.
`ifndef LED_MATRIX_DRAW_ENGINE_ASSERT_SVH
`define LED_MATRIX_DRAW_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define LMDE_ASSERT_SAME(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("assertion failed");
`define LMDE_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed");
`else
`define LMDE_ASSERT_SAME(label, clk, rst_n, trig, cons)
`define LMDE_ASSERT_NEXT(label, clk, rst_n, trig, cons)
`endif
`endif

@@ design/lmde_pkg.sv @@
`timescale 1ns / 1ps
package lmde_pkg;

  // Request codes
  localparam logic [2:0] REQ_PIXEL  = 3'd0;
  localparam logic [2:0] REQ_ROW    = 3'd1;
  localparam logic [2:0] REQ_COLUMN = 3'd2;
  localparam logic [2:0] REQ_ALL    = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;
  localparam logic [2:0] REQ_SQUARE = 3'd5;
  localparam logic [2:0] REQ_SCAN   = 3'd6;

  // Colour codes
  localparam logic [2:0] COL_RED    = 3'd0;
  localparam logic [2:0] COL_GREEN  = 3'd1;
  localparam logic [2:0] COL_BLUE   = 3'd2;
  localparam logic [2:0] COL_WHITE  = 3'd3;
  localparam logic [2:0] COL_YELLOW = 3'd4;
  localparam logic [2:0] COL_PURPLE = 3'd5;

  localparam logic [7:0] DEFAULT_BLUE = 8'd3;

  typedef struct packed {
    logic [2:0] req_type;
    logic [6:0] position;
    logic [2:0] color_code;
    logic [7:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  pixel_number;
    logic [23:0] grb_word;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_SCAN_TAIL
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic wr_en;
    logic rd_en;
    logic clear_all;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_write;
    logic go_clear;
    logic go_scan;
    logic cnt_last;
  } dp_status_t;

  // Colour code and brightness to a GRB word; products wrap at 8 bits
  function automatic logic [23:0] make_grb(input logic [2:0] code, input logic [7:0] bright);
    logic [7:0] x3;
    logic [7:0] x4;
    logic [7:0] x10;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] bl;
    x3  = 8'({bright, 1'b0} + {1'b0, bright});
    x4  = 8'({bright, 2'b00});
    x10 = 8'({bright, 3'b000} + {2'b00, bright, 1'b0});
    r   = '0;
    g   = '0;
    bl  = '0;
    case (code)
      COL_RED:    r = x3;
      COL_GREEN:  g = x3;
      COL_BLUE:   bl = x3;
      COL_WHITE: begin
        r  = x3;
        g  = x3;
        bl = x3;
      end
      COL_YELLOW: begin
        r = x3;
        g = x3;
      end
      COL_PURPLE: begin
        r  = x4;
        bl = x10;
      end
      default:    bl = DEFAULT_BLUE;
    endcase
    return {g, r, bl};
  endfunction

endpackage

@@ design/led_matrix_draw_engine.sv @@
`timescale 1ns / 1ps
// Channel   | Ports                        | Handshake
// ----------+------------------------------+-------------------------------------
// input     | start, busy, in_item         | beat taken when start && !busy
// result    | out_valid, out_item          | cannot be held off
//
// An accepted item writes one pixel a cycle through the single write port of
// the frame store: a pixel request 1 pixel, a square 4, a row COLUMNS, a
// column ROWS and all ROWS*COLUMNS. Clear and ignored requests finish in the
// accept cycle. A scan reads one pixel a cycle, ROWS*COLUMNS in all, each
// through the registered read. Reset is synchronous and leaves every pixel
// off at once; no clearing pass is needed.
module led_matrix_draw_engine #(
  parameter int COLUMNS = 8,
  parameter int ROWS    = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lmde_pkg::in_item_t  in_item,
  output logic                out_valid,
  output lmde_pkg::out_item_t out_item
);
  import lmde_pkg::*;

  `include "led_matrix_draw_engine_assert.svh"

  dp_cmd_t    cmd;
  dp_status_t status;

  lmde_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  lmde_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Checks
  `LMDE_ASSERT_SAME(a_out_while_busy, clk, rst_n, out_valid, busy)
  `LMDE_ASSERT_SAME(a_last_is_final, clk, rst_n, out_valid && out_item.last, out_item.pixel_number == 7'(ROWS * COLUMNS))
  `LMDE_ASSERT_NEXT(a_last_ends_scan, clk, rst_n, out_valid && out_item.last, !out_valid && !busy)
  `LMDE_ASSERT_SAME(a_no_rd_wr_clash, clk, rst_n, cmd.wr_en, !cmd.rd_en && !cmd.load)

endmodule

@@ design/lmde_ram.sv @@
`timescale 1ns / 1ps
module lmde_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/lmde_ctrl.sv @@
`timescale 1ns / 1ps
module lmde_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lmde_pkg::dp_status_t status,
  output lmde_pkg::dp_cmd_t    cmd
);
  import lmde_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && status.go_write) begin
          state_nxt = ST_WRITE;
        end else if (start && status.go_scan) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_WRITE: begin
        if (status.cnt_last) state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        if (status.cnt_last) state_nxt = ST_SCAN_TAIL;
      end
      ST_SCAN_TAIL: state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy          = 1'b0;
        cmd.load      = start;
        cmd.clear_all = start && status.go_clear;
      end
      ST_WRITE:     cmd.wr_en = 1'b1;
      ST_SCAN:      cmd.rd_en = 1'b1;
      ST_SCAN_TAIL: busy = 1'b1;
      default:      busy = 1'b1;
    endcase
  end

endmodule

@@ design/lmde_datapath.sv @@
`timescale 1ns / 1ps
module lmde_datapath #(
  parameter int COLUMNS = 8,
  parameter int ROWS    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lmde_pkg::in_item_t   in_item,
  input  lmde_pkg::dp_cmd_t    cmd,
  output lmde_pkg::dp_status_t status,
  output logic                 out_valid,
  output lmde_pkg::out_item_t  out_item
);
  import lmde_pkg::*;

  localparam int PIXELS = ROWS * COLUMNS;
  localparam int AW     = $clog2(PIXELS);
  localparam int CW     = $clog2(PIXELS + 1);
  localparam int SQ_MAX = COLUMNS * (ROWS - 1) - 1;

  // Positions in the last column, for the square check
  logic [127:0] last_col;
  for (genvar gi = 0; gi < 128; gi++) begin : g_last_col
    assign last_col[gi] = ((gi % COLUMNS) == 0);
  end

  logic [6:0]    pos;
  logic [6:0]    pos_m1;
  logic          pos_nz;
  logic          go_write;
  logic          go_clear;
  logic          go_scan;
  logic          is_sq;
  logic [6:0]    start_addr;
  logic [AW-1:0] start_step;
  logic [CW-1:0] start_cnt;

  logic [AW-1:0]   addr_r;
  logic [AW-1:0]   step_r;
  logic [CW-1:0]   cnt_r;
  logic            sq_r;
  logic [23:0]     word_r;
  logic [PIXELS-1:0] valid_r;
  logic [AW-1:0]   addr_nxt;

  logic            show_r;
  logic            vld_rd_r;
  logic [6:0]      num_r;
  logic            last_r;
  logic [23:0]     rd_data;

  assign pos    = in_item.position;
  assign pos_m1 = pos - 7'd1;
  assign pos_nz = (pos != 7'd0);

  // Request decode: range checks and walk set-up
  always_comb begin
    go_write   = 1'b0;
    go_clear   = 1'b0;
    go_scan    = 1'b0;
    is_sq      = 1'b0;
    start_addr = pos_m1;
    start_step = AW'(1);
    start_cnt  = CW'(1);
    unique case (in_item.req_type)
      REQ_PIXEL: begin
        go_write = pos_nz && (pos <= 7'(PIXELS));
      end
      REQ_ROW: begin
        go_write   = pos_nz && (pos <= 7'(ROWS));
        start_addr = 7'(pos_m1 * 7'(COLUMNS));
        start_cnt  = CW'(COLUMNS);
      end
      REQ_COLUMN: begin
        go_write   = pos_nz && (pos <= 7'(COLUMNS));
        start_step = AW'(COLUMNS);
        start_cnt  = CW'(ROWS);
      end
      REQ_ALL: begin
        go_write   = 1'b1;
        start_addr = 7'd0;
        start_cnt  = CW'(PIXELS);
      end
      REQ_CLEAR: go_clear = 1'b1;
      REQ_SQUARE: begin
        go_write  = pos_nz && (pos <= 7'(SQ_MAX)) && !last_col[pos];
        is_sq     = 1'b1;
        start_cnt = CW'(4);
      end
      REQ_SCAN: begin
        go_scan    = 1'b1;
        start_addr = 7'd0;
        start_cnt  = CW'(PIXELS);
      end
      default: ;
    endcase
  end

  assign status.go_write = go_write;
  assign status.go_clear = go_clear;
  assign status.go_scan  = go_scan;
  assign status.cnt_last = (cnt_r == CW'(1));

  // Square walk: +1, +COLUMNS-1, +1
  assign addr_nxt = (sq_r && cnt_r == CW'(3)) ? addr_r + AW'(COLUMNS - 1)
                                              : addr_r + step_r;

  // Walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= AW'(start_addr);
      step_r <= start_step;
      cnt_r  <= start_cnt;
      sq_r   <= is_sq;
      word_r <= make_grb(in_item.color_code, in_item.brightness);
    end else if (cmd.wr_en || cmd.rd_en) begin
      addr_r <= addr_nxt;
      cnt_r  <= cnt_r - CW'(1);
    end
  end

  // Written flags: an unwritten pixel reads as off
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      valid_r <= '0;
    end else if (cmd.wr_en) begin
      valid_r[addr_r] <= 1'b1;
    end
  end

  lmde_ram #(
    .WIDTH (24),
    .DEPTH (PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (addr_r),
    .wdata (word_r),
    .re    (cmd.rd_en),
    .raddr (addr_r),
    .rdata (rd_data)
  );

  // Scan beat, aligned with the registered read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_r <= 1'b0;
    end else begin
      show_r <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      vld_rd_r <= valid_r[addr_r];
      num_r    <= 7'(addr_r) + 7'd1;
      last_r   <= status.cnt_last;
    end
  end

  assign out_valid             = show_r;
  assign out_item.pixel_number = num_r;
  assign out_item.grb_word     = vld_rd_r ? rd_data : 24'd0;
  assign out_item.last         = last_r;

endmodule
